/* src/indexed_list_store_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the indexed list store
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_STORE_MACROS_SVH
`define INDEXED_LIST_STORE_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every clock edge outside reset
`define ILS_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("indexed list store assertion failed");
// Check a property on every clock edge, reset included
`define ILS_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) (prop)) \
    else $error("indexed list store assertion failed");
`else
`define ILS_ASSERT(name, prop)
`define ILS_ASSERT_ALWAYS(name, prop)
`endif

`endif

/* src/ils_pkg.sv */
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types and constants of the indexed list store.
// ----------------------------------------------------------------------------
package ils_pkg;

  // Default sizes
  localparam int unsigned IlsCapacity  = 64;
  localparam int unsigned IlsElemWidth = 32;

  // Fixed field widths
  localparam int unsigned OpW     = 3;
  localparam int unsigned IndexW  = 8;
  localparam int unsigned DataW   = 32;
  localparam int unsigned PosOutW = 7;
  localparam int unsigned StatusW = 2;
  localparam int unsigned LenOutW = 7;

  // Operation codes
  typedef enum logic [OpW-1:0] {
    OP_GET    = 3'd0,
    OP_SET    = 3'd1,
    OP_INSERT = 3'd2,
    OP_APPEND = 3'd3,
    OP_REMOVE = 3'd4,
    OP_EMPTY  = 3'd5
  } op_e;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_INDEX = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Command broadcast to every cell of the row
  typedef enum logic [2:0] {
    CELL_IDLE,
    CELL_WRITE,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_READ
  } cell_cmd_e;

  // Controller sequence
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_GATHER
  } ctrl_state_e;

endpackage

/* src/ils_cell.sv */
// ----------------------------------------------------------------------------
// ils_cell
// One list slot: holds an element, takes its neighbour's element on a shift
// and taps its element onto the read path when addressed.
// ----------------------------------------------------------------------------
module ils_cell #(
  parameter int unsigned ELEMENT_WIDTH = 32,
  parameter int unsigned PosW          = 6,
  parameter int unsigned Idx           = 0
) (
  input  logic                     clk_i,
  input  ils_pkg::cell_cmd_e       cmd_i,
  input  logic [PosW-1:0]          pos_i,
  input  logic [ELEMENT_WIDTH-1:0] value_i,
  input  logic [ELEMENT_WIDTH-1:0] left_i,
  input  logic [ELEMENT_WIDTH-1:0] right_i,
  output logic [ELEMENT_WIDTH-1:0] data_o,
  output logic [ELEMENT_WIDTH-1:0] rd_o
);
  import ils_pkg::*;

  localparam logic [PosW-1:0] MyPos = PosW'(Idx);

  logic [ELEMENT_WIDTH-1:0] elem_q, elem_d;
  logic [ELEMENT_WIDTH-1:0] rd_q, rd_d;

  // Pick the new element for this slot
  always_comb begin
    elem_d = elem_q;
    rd_d   = rd_q;
    case (cmd_i)
      CELL_WRITE: begin
        if (pos_i == MyPos) elem_d = value_i;
      end
      CELL_INSERT: begin
        if (MyPos > pos_i) begin
          elem_d = left_i;
        end else if (MyPos == pos_i) begin
          elem_d = value_i;
        end
      end
      CELL_REMOVE: begin
        if (MyPos >= pos_i) elem_d = right_i;
      end
      CELL_READ: begin
        rd_d = (pos_i == MyPos) ? elem_q : '0;
      end
      default: begin
      end
    endcase
  end

  // Hold element and read tap
  always_ff @(posedge clk_i) begin
    elem_q <= elem_d;
    rd_q   <= rd_d;
  end

  assign data_o = elem_q;
  assign rd_o   = rd_q;

endmodule

/* src/ils_cell_row.sv */
// ----------------------------------------------------------------------------
// ils_cell_row
// Chain of list cells with neighbour links for shifts and the merged read
// path from the per-cell taps.
// ----------------------------------------------------------------------------
module ils_cell_row #(
  parameter int unsigned CAPACITY      = 64,
  parameter int unsigned ELEMENT_WIDTH = 32,
  parameter int unsigned PosW          = 6
) (
  input  logic                     clk_i,
  input  ils_pkg::cell_cmd_e       cmd_i,
  input  logic [PosW-1:0]          pos_i,
  input  logic [ELEMENT_WIDTH-1:0] value_i,
  output logic [ELEMENT_WIDTH-1:0] rd_o
);
  import ils_pkg::*;

  logic [ELEMENT_WIDTH-1:0] cell_data [CAPACITY];
  logic [ELEMENT_WIDTH-1:0] cell_rd   [CAPACITY];

  // Build the chain; the end cells feed back their own element
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [ELEMENT_WIDTH-1:0] left, right;

    if (k == 0) begin : g_first
      assign left = cell_data[k];
    end else begin : g_mid_l
      assign left = cell_data[k-1];
    end

    if (k == CAPACITY - 1) begin : g_last
      assign right = cell_data[k];
    end else begin : g_mid_r
      assign right = cell_data[k+1];
    end

    ils_cell #(
      .ELEMENT_WIDTH(ELEMENT_WIDTH),
      .PosW         (PosW),
      .Idx          (k)
    ) u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd_i),
      .pos_i  (pos_i),
      .value_i(value_i),
      .left_i (left),
      .right_i(right),
      .data_o (cell_data[k]),
      .rd_o   (cell_rd[k])
    );
  end

  // Merge the read taps; at most one is non-zero
  always_comb begin
    rd_o = '0;
    for (int unsigned k = 0; k < CAPACITY; k++) begin
      rd_o = rd_o | cell_rd[k];
    end
  end

endmodule

/* src/indexed_list_store.sv */
// ----------------------------------------------------------------------------
// indexed_list_store
// Ordered list with get, set, insert, append, remove and empty operations on
// a chain of cells that shift in parallel.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  request | in_valid_i, in_stall_o, op_i, index_i,    | in
//          | value_i                                   |
//  result  | out_valid_o, out_stall_i, read_value_o,   | out
//          | position_o, status_o, length_o            |
//
//  An operation runs through accept, execute across the cell row and
//  gather of the read taps into the output register. A new transaction is
//  taken only once the gather step is done and the control is idle again.
//  A stalled result holds the gather step; the next request is still taken
//  while a finished result waits to be collected.
//  Reset clears the control state, valid flag and element count, not the cells; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "indexed_list_store_macros.svh"

module indexed_list_store #(
  parameter int unsigned CAPACITY      = ils_pkg::IlsCapacity,
  parameter int unsigned ELEMENT_WIDTH = ils_pkg::IlsElemWidth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [ils_pkg::OpW-1:0]      op_i,
  input  logic signed [ils_pkg::IndexW-1:0] index_i,
  input  logic [ils_pkg::DataW-1:0]    value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [ils_pkg::DataW-1:0]    read_value_o,
  output logic [ils_pkg::PosOutW-1:0]  position_o,
  output logic [ils_pkg::StatusW-1:0]  status_o,
  output logic [ils_pkg::LenOutW-1:0]  length_o
);
  import ils_pkg::*;

  localparam int unsigned PosW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned SumW = ((CntW > IndexW) ? CntW : IndexW) + 2;
  localparam logic [CntW-1:0] CapCount = CntW'(CAPACITY);

  ctrl_state_e state_q, state_d;

  // Request registers
  logic [OpW-1:0]           op_q;
  logic [IndexW-1:0]        index_q;
  logic [ELEMENT_WIDTH-1:0] value_q;
  logic [CntW-1:0]          count_q, count_d;

  // Execute results waiting for the gather step
  logic [SumW-1:0] res_pos_q, res_pos_d;
  status_e         res_status_q, res_status_d;
  logic            res_read_q, res_read_d;

  // Output register
  logic                 out_valid_q;
  logic [DataW-1:0]     read_value_q;
  logic [PosOutW-1:0]   position_q;
  logic [StatusW-1:0]   status_q;
  logic [LenOutW-1:0]   length_q;

  // Cell row control
  cell_cmd_e                cell_cmd;
  logic [PosW-1:0]          cell_pos;
  logic [ELEMENT_WIDTH-1:0] row_rd;

  logic signed [SumW-1:0] idx_s, cnt_s, norm_s, limit_s;
  logic                   is_ins, idx_ok, is_full, in_acc, out_load;

  assign in_acc   = in_valid_i && (state_q == S_IDLE);
  assign out_load = (state_q == S_GATHER) && (!out_valid_q || !out_stall_i);
  assign is_full  = (count_q == CapCount);

  // Normalise the index against the current length
  always_comb begin
    is_ins  = (op_q == OP_INSERT);
    idx_s   = $signed({{(SumW-IndexW){index_q[IndexW-1]}}, index_q});
    cnt_s   = $signed(SumW'(count_q));
    limit_s = cnt_s + $signed(SumW'(is_ins));
    norm_s  = idx_s[SumW-1] ? (idx_s + limit_s) : idx_s;
    idx_ok  = !norm_s[SumW-1] && (norm_s < limit_s);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_acc) state_d = S_EXEC;
      S_EXEC:   state_d = S_GATHER;
      S_GATHER: if (out_load) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Execute step: cell command, new length and result fields
  always_comb begin
    cell_cmd     = CELL_IDLE;
    cell_pos     = norm_s[PosW-1:0];
    count_d      = count_q;
    res_pos_d    = res_pos_q;
    res_status_d = res_status_q;
    res_read_d   = res_read_q;
    if (state_q == S_EXEC) begin
      res_pos_d    = '0;
      res_status_d = ST_OK;
      res_read_d   = 1'b0;
      case (op_q)
        OP_GET, OP_SET, OP_REMOVE: begin
          if (!idx_ok) begin
            res_status_d = ST_INDEX;
          end else begin
            res_pos_d = norm_s;
            if (op_q == OP_GET) begin
              cell_cmd   = CELL_READ;
              res_read_d = 1'b1;
            end else if (op_q == OP_SET) begin
              cell_cmd = CELL_WRITE;
            end else begin
              cell_cmd = CELL_REMOVE;
              count_d  = count_q - CntW'(1);
            end
          end
        end
        OP_INSERT: begin
          if (!idx_ok) begin
            res_status_d = ST_INDEX;
          end else if (is_full) begin
            res_status_d = ST_FULL;
          end else begin
            res_pos_d = norm_s;
            cell_cmd  = CELL_INSERT;
            count_d   = count_q + CntW'(1);
          end
        end
        OP_APPEND: begin
          if (is_full) begin
            res_status_d = ST_FULL;
          end else begin
            res_pos_d = SumW'(count_q);
            cell_cmd  = CELL_WRITE;
            cell_pos  = count_q[PosW-1:0];
            count_d   = count_q + CntW'(1);
          end
        end
        OP_EMPTY: begin
          count_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  ils_cell_row #(
    .CAPACITY     (CAPACITY),
    .ELEMENT_WIDTH(ELEMENT_WIDTH),
    .PosW         (PosW)
  ) u_row (
    .clk_i  (clk_i),
    .cmd_i  (cell_cmd),
    .pos_i  (cell_pos),
    .value_i(value_q),
    .rd_o   (row_rd)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= op_i;
      index_q <= index_i;
      value_q <= ELEMENT_WIDTH'(value_i);
    end
    res_pos_q    <= res_pos_d;
    res_status_q <= res_status_d;
    res_read_q   <= res_read_d;
    if (out_load) begin
      read_value_q <= res_read_q ? DataW'(row_rd) : '0;
      position_q   <= res_pos_q[PosOutW-1:0];
      status_q     <= res_status_q;
      length_q     <= LenOutW'(count_q);
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign read_value_o = read_value_q;
  assign position_o   = position_q;
  assign status_o     = status_q;
  assign length_o     = length_q;

  // Checks
  `ILS_ASSERT(a_count_bound, count_q <= CapCount)
  `ILS_ASSERT(a_accept_exec, in_valid_i && !in_stall_o |=> state_q == S_EXEC)
  `ILS_ASSERT(a_exec_gather, state_q == S_EXEC |=> state_q == S_GATHER)
  `ILS_ASSERT(a_count_only_exec, state_q != S_EXEC |=> $stable(count_q))
  `ILS_ASSERT(a_full_count, state_q == S_GATHER && res_status_q == ST_FULL |-> is_full)

endmodule

/* tb/indexed_list_store_tb.sv */
// ----------------------------------------------------------------------------
// indexed_list_store_tb
// Self-checking bench for the indexed list store. A shadow list predicts
// every result as each request transaction is accepted; a monitor compares
// the collected results field by field, in order. Directed cases cover the
// index edges, every operation and the full list, followed by back-pressure,
// back-to-back and randomly mixed traffic with random idling on both sides.
// ----------------------------------------------------------------------------
module indexed_list_store_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ils_pkg::*;

  localparam int ClkPeriod     = 8;
  localparam int ResetCycles   = 5;
  localparam int Capacity      = ils_pkg::IlsCapacity;
  localparam int SettleCycles  = 8;
  localparam int LongHold      = 200;
  localparam int TimeoutCycles = 600000;

  // Op codes the block must treat as no-ops
  localparam logic [OpW-1:0] OpSpareLo = 3'd6;
  localparam logic [OpW-1:0] OpSpareHi = 3'd7;

  typedef enum int {MIX_GROW, MIX_EVEN, MIX_SHRINK} mix_e;

  typedef struct packed {
    logic [DataW-1:0]   read_value;
    logic [PosOutW-1:0] position;
    status_e            status;
    logic [LenOutW-1:0] length;
  } list_result_t;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  logic [OpW-1:0]           op_i        = '0;
  logic signed [IndexW-1:0] index_i     = '0;
  logic [DataW-1:0]         value_i     = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [DataW-1:0]         read_value_o;
  logic [PosOutW-1:0]       position_o;
  logic [StatusW-1:0]       status_o;
  logic [LenOutW-1:0]       length_o;

  // Shadow copy of the list
  logic [DataW-1:0] shadow_elems [Capacity];
  int               shadow_count = 0;

  list_result_t pending_results [$];

  int  mismatches      = 0;
  int  requests_sent   = 0;
  int  results_checked = 0;
  int  index_errors    = 0;
  int  full_errors     = 0;
  int  peak_length     = 0;
  bit  gaps_on         = 1'b1;
  bit  stall_on        = 1'b1;
  int  hold_off_req    = 0;

  indexed_list_store dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .index_i     (index_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .read_value_o(read_value_o),
    .position_o  (position_o),
    .status_o    (status_o),
    .length_o    (length_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Apply one operation to the shadow list and return the result it gives
  function automatic list_result_t predict_list_op(input logic [OpW-1:0] op,
                                                   input logic signed [IndexW-1:0] index,
                                                   input logic [DataW-1:0] value);
    list_result_t res;
    int pos;
    res = '{read_value: '0, position: '0, status: ST_OK, length: '0};
    pos = 0;
    case (op)
      OP_GET, OP_SET, OP_REMOVE: begin
        pos = int'(index);
        if (pos < 0) pos = shadow_count + pos;
        if (pos < 0 || pos >= shadow_count) begin
          res.status = ST_INDEX;
          pos = 0;
        end else if (op == OP_GET) begin
          res.read_value = shadow_elems[pos];
        end else if (op == OP_SET) begin
          shadow_elems[pos] = value;
        end else begin
          for (int i = pos; i + 1 < shadow_count; i++) shadow_elems[i] = shadow_elems[i + 1];
          shadow_count--;
        end
      end
      OP_INSERT: begin
        pos = int'(index);
        if (pos < 0) pos = shadow_count + pos + 1;
        if (pos < 0 || pos > shadow_count) begin
          res.status = ST_INDEX;
          pos = 0;
        end else if (shadow_count >= Capacity) begin
          res.status = ST_FULL;
          pos = 0;
        end else begin
          for (int i = shadow_count; i > pos; i--) shadow_elems[i] = shadow_elems[i - 1];
          shadow_elems[pos] = value;
          shadow_count++;
        end
      end
      OP_APPEND: begin
        if (shadow_count >= Capacity) begin
          res.status = ST_FULL;
        end else begin
          pos = shadow_count;
          shadow_elems[shadow_count] = value;
          shadow_count++;
        end
      end
      OP_EMPTY: shadow_count = 0;
      default: ;
    endcase
    if (res.status == ST_INDEX) index_errors++;
    if (res.status == ST_FULL) full_errors++;
    if (shadow_count > peak_length) peak_length = shadow_count;
    res.position = pos[PosOutW-1:0];
    res.length   = shadow_count[LenOutW-1:0];
    return res;
  endfunction

  // Idle length: mostly short, now and then long
  function automatic int idle_len();
    if ($urandom_range(99) < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [DataW-1:0] rand_value();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return $urandom;
  endfunction

  // Any raw index byte
  function automatic logic signed [IndexW-1:0] raw_index();
    return IndexW'($urandom_range(255));
  endfunction

  // Mostly legal positions, in either form, plus edges and raw noise
  function automatic logic signed [IndexW-1:0] pick_index(input bit for_insert);
    int span;
    int r;
    int p;
    span = for_insert ? shadow_count + 1 : shadow_count;
    r = $urandom_range(99);
    if (r < 80 && span > 0) begin
      p = $urandom_range(span - 1);
      return $urandom_range(1) ? IndexW'(p - span) : IndexW'(p);
    end
    if (r < 94) begin
      case ($urandom_range(3))
        0:       return IndexW'(span);
        1:       return IndexW'(-span - 1);
        2:       return IndexW'(span + int'($urandom_range(1, 8)));
        default: return IndexW'(-span - 1 - int'($urandom_range(1, 8)));
      endcase
    end
    return raw_index();
  endfunction

  // Offer one request transaction and hold it until it is taken
  task automatic send_op(input logic [OpW-1:0] op, input logic signed [IndexW-1:0] index,
                         input logic [DataW-1:0] value);
    int gap;
    in_valid_i <= 1'b1;
    op_i       <= op;
    index_i    <= index;
    value_i    <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(predict_list_op(op, index, value));
    requests_sent++;
    gap = (gaps_on && $urandom_range(99) < 40) ? idle_len() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic issue_random_op(input mix_e mix);
    int w_ins;
    int w_app;
    int w_rem;
    int w_clr;
    int r;
    case (mix)
      MIX_GROW:   begin w_ins = 30; w_app = 25; w_rem = 10; w_clr = 0; end
      MIX_SHRINK: begin w_ins = 8;  w_app = 4;  w_rem = 45; w_clr = 1; end
      default:    begin w_ins = 20; w_app = 12; w_rem = 24; w_clr = 2; end
    endcase
    r = $urandom_range(99);
    if (r < w_ins) begin
      send_op(OP_INSERT, pick_index(1'b1), rand_value());
    end else if (r < w_ins + w_app) begin
      send_op(OP_APPEND, raw_index(), rand_value());
    end else if (r < w_ins + w_app + w_rem) begin
      send_op(OP_REMOVE, pick_index(1'b0), rand_value());
    end else if (r < w_ins + w_app + w_rem + w_clr) begin
      send_op(OP_EMPTY, raw_index(), rand_value());
    end else if (r < w_ins + w_app + w_rem + w_clr + 3) begin
      send_op($urandom_range(1) ? OpSpareHi : OpSpareLo, raw_index(), rand_value());
    end else if (r < w_ins + w_app + w_rem + w_clr + 18) begin
      send_op(OP_SET, pick_index(1'b0), rand_value());
    end else begin
      send_op(OP_GET, pick_index(1'b0), rand_value());
    end
  endtask

  // Drop valid and wait for every outstanding result
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic reset_dut();
    rst_ni <= 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
  endtask

  // Index edges, every operation and the spare op codes on a short list
  task automatic test_directed_ops();
    send_op(OP_GET, 0, 32'h1111_1111);
    send_op(OP_REMOVE, -1, 32'h0);
    send_op(OP_APPEND, 0, 32'hFFFF_FFFF);
    send_op(OP_APPEND, -128, 32'h0000_0000);
    send_op(OP_INSERT, -1, 32'h1234_5678);
    send_op(OP_INSERT, 0, 32'hA5A5_A5A5);
    send_op(OP_INSERT, 2, 32'h5A5A_5A5A);
    send_op(OP_GET, -1, 32'h0);
    send_op(OP_GET, 0, 32'h0);
    send_op(OP_GET, 4, 32'h0);
    send_op(OP_GET, 5, 32'h0);
    send_op(OP_GET, -6, 32'h0);
    send_op(OP_GET, -5, 32'h0);
    send_op(OP_SET, -2, 32'hDEAD_BEEF);
    send_op(OP_SET, 127, 32'hFFFF_FFFF);
    send_op(OP_GET, -128, 32'h0);
    send_op(OP_INSERT, 6, 32'h0BAD_0BAD);
    send_op(OP_INSERT, -7, 32'h0BAD_0BAD);
    send_op(OP_INSERT, -6, 32'hC0DE_0001);
    send_op(OP_REMOVE, 1, 32'hFFFF_FFFF);
    send_op(OP_REMOVE, -1, 32'h0);
    send_op(OpSpareLo, 8'sh55, 32'hFFFF_FFFF);
    send_op(OpSpareHi, -86, 32'h5555_5555);
    send_op(OP_EMPTY, 127, 32'hFFFF_FFFF);
    send_op(OP_GET, 0, 32'h0);
    send_op(OP_APPEND, 0, 32'h0000_FFFF);
    wait_for_results();
  endtask

  // Fill to capacity, then hit the full and double-fault paths
  task automatic test_full_list();
    while (shadow_count < Capacity) send_op(OP_APPEND, raw_index(), rand_value());
    send_op(OP_APPEND, 0, 32'hFFFF_FFFF);
    send_op(OP_INSERT, 0, 32'hFFFF_FFFF);
    send_op(OP_INSERT, -1, 32'hFFFF_FFFF);
    send_op(OP_INSERT, 65, 32'hFFFF_FFFF);
    send_op(OP_INSERT, -66, 32'hFFFF_FFFF);
    send_op(OP_GET, 63, 32'h0);
    send_op(OP_GET, -64, 32'h0);
    send_op(OP_GET, 64, 32'h0);
    send_op(OP_SET, -1, 32'h0);
    send_op(OP_REMOVE, 0, 32'h0);
    send_op(OP_INSERT, 63, 32'h8000_0001);
    send_op(OP_REMOVE, -64, 32'h0);
    send_op(OP_INSERT, -64, 32'h7FFF_FFFE);
    send_op(OP_GET, 0, 32'h0);
    wait_for_results();
  endtask

  // Hold the result side off for a long stretch while requests keep coming
  task automatic test_back_pressure();
    gaps_on = 1'b0;
    hold_off_req <= hold_off_req + 1;
    repeat (30) issue_random_op(MIX_EVEN);
    wait_for_results();
    gaps_on = 1'b1;
  endtask

  // Full rate on both sides
  task automatic test_back_to_back();
    gaps_on = 1'b0;
    stall_on <= 1'b0;
    repeat (100) issue_random_op(MIX_EVEN);
    wait_for_results();
    gaps_on = 1'b1;
    stall_on <= 1'b1;
  endtask

  // Phases that push the length up, hold it steady, pull it down and push it up again
  task automatic test_random_mix();
    repeat (250) issue_random_op(MIX_GROW);
    repeat (250) issue_random_op(MIX_EVEN);
    repeat (170) issue_random_op(MIX_SHRINK);
    repeat (200) issue_random_op(MIX_GROW);
  endtask

  // Result-side stall: requested long hold first, then random idling
  always @(posedge clk_i) begin : stall_gen
    int hold_seen;
    int hold_left;
    int stall_left;
    if (hold_off_req != hold_seen) begin
      hold_seen = hold_off_req;
      hold_left = LongHold;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (!stall_on) begin
      stall_left = 0;
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      if ($urandom_range(99) < 30) stall_left = idle_len();
    end
  end

  // Compare each collected result with the oldest prediction
  always @(posedge clk_i) begin : result_check
    list_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        $error("result transaction with no request outstanding");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (read_value_o !== want.read_value) begin
          $error("read_value expected %0h actual %0h", want.read_value, read_value_o);
          mismatches++;
        end
        if (position_o !== want.position) begin
          $error("position expected %0d actual %0d", want.position, position_o);
          mismatches++;
        end
        if (status_o !== want.status) begin
          $error("status expected %0d actual %0d", want.status, status_o);
          mismatches++;
        end
        if (length_o !== want.length) begin
          $error("length expected %0d actual %0d", want.length, length_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    reset_dut();
    test_directed_ops();
    test_full_list();
    test_back_pressure();
    test_back_to_back();
    test_random_mix();
    wait_for_results();
    $display("Ran %0d list operations (%0d index errors, %0d full errors), checked %0d results.",
             requests_sent, index_errors, full_errors, results_checked);
    $display("Peak length %0d of %0d over directed, full-list, hold-off and random phases.",
             peak_length, Capacity);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("FAILURE");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/ils_pkg.sv
src/ils_cell.sv
src/ils_cell_row.sv
src/indexed_list_store.sv
tb/indexed_list_store_tb.sv
